[hdl/cce_pkg.sv]
`default_nettype none
package cce_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam int MAX_RES   = 3;
  localparam int RBUF_DEPTH = 4;
  localparam int RBUF_AW    = $clog2(RBUF_DEPTH);
  localparam int RBUF_CW    = $clog2(RBUF_DEPTH + 1);
  localparam int RES_CW     = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic [RES_CW-1:0]           n;
    logic [MAX_RES-1:0][7:0]     bytes;
  } res_bundle_t;

endpackage
`default_nettype wire

[hdl/cce_in_if.sv]
`default_nettype none
interface cce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

[hdl/cce_out_if.sv]
`default_nettype none
interface cce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

[hdl/c_comment_line_extractor.sv]
// Comment line extractor: takes source text one byte per transfer on din and
// returns the bytes of C comments on dout, each comment line closed by a
// newline, with run_last marking the final byte caused by each input byte.
// One byte is held back as lookahead, so the output lags the input by one
// byte; in_last flushes it and resets the scanner for a new stream. Throughput
// is one input byte per cycle: judging is a single clocked pass against the
// held byte, and results go through a four-entry queue that drains one byte per
// cycle, so only a dout stall or the stream-end byte (up to three results) costs
// extra cycles. din.ready drops at two or more queued results. No clearing pass.
`default_nettype none
module c_comment_line_extractor (
  input  wire logic   clk,
  input  wire logic   rst,
  cce_in_if.sink      din,
  cce_out_if.source   dout
);

  cce_pkg::res_bundle_t res;
  cce_pkg::res_t        head;
  logic                 room;
  logic                 take;

  assign din.ready = room;
  assign take      = din.valid && room;

  cce_judge u_judge (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (din.in_byte),
    .in_last (din.in_last),
    .res     (res)
  );

  cce_rbuf u_rbuf (
    .clk   (clk),
    .rst   (rst),
    .res   (res),
    .room  (room),
    .valid (dout.valid),
    .ready (dout.ready),
    .head  (head)
  );

  assign dout.out_byte = head.out_byte;
  assign dout.run_last = head.run_last;

endmodule
`default_nettype wire

[hdl/cce_judge.sv]
`default_nettype none
module cce_judge (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_last,
  output cce_pkg::res_bundle_t     res
);

  logic [7:0] held_char;
  logic       held_valid;
  logic       in_comment;
  logic       block_open;

  logic [7:0] held_char_next;
  logic       held_valid_next;
  logic       in_comment_next;
  logic       block_open_next;

  logic [2:0] j0;
  logic [2:0] j1;
  logic       e0;
  logic       e1;
  logic       e2;

  // returns {in_comment, block_open, emit}
  function automatic logic [2:0] judge_f(input logic ic, input logic bo,
                                         input logic [7:0] x, input logic [7:0] n);
    logic ic_v;
    logic bo_v;
    logic emit;
    ic_v = ic;
    bo_v = bo;
    emit = 1'b0;
    if (!ic_v && x == cce_pkg::CH_SLASH &&
        (n == cce_pkg::CH_SLASH || n == cce_pkg::CH_STAR)) begin
      ic_v = 1'b1;
      if (n == cce_pkg::CH_STAR) bo_v = 1'b1;
    end
    if (ic_v) begin
      emit = 1'b1;
      if (x == cce_pkg::CH_NL) begin
        if (!bo_v) ic_v = 1'b0;
      end else if (x == cce_pkg::CH_STAR && n == cce_pkg::CH_SLASH) begin
        bo_v = 1'b0;
      end
    end
    return {ic_v, bo_v, emit};
  endfunction

  always_comb begin
    j0 = {in_comment, block_open, 1'b0};
    if (held_valid) j0 = judge_f(in_comment, block_open, held_char, in_byte);
    j1 = judge_f(j0[2], j0[1], in_byte, 8'h00);

    e0 = take && j0[0];
    e1 = take && in_last && j1[0];
    e2 = take && in_last && j1[2] && in_byte != cce_pkg::CH_NL;

    res.n = cce_pkg::RES_CW'({1'b0, e0} + {1'b0, e1} + {1'b0, e2});
    res.bytes[0] = e0 ? held_char : (e1 ? in_byte : cce_pkg::CH_NL);
    res.bytes[1] = (e0 && e1) ? in_byte : cce_pkg::CH_NL;
    res.bytes[2] = cce_pkg::CH_NL;

    held_char_next  = held_char;
    held_valid_next = held_valid;
    in_comment_next = in_comment;
    block_open_next = block_open;
    if (take) begin
      if (in_last) begin
        held_char_next  = 8'h00;
        held_valid_next = 1'b0;
        in_comment_next = 1'b0;
        block_open_next = 1'b0;
      end else begin
        held_char_next  = in_byte;
        held_valid_next = 1'b1;
        in_comment_next = j0[2];
        block_open_next = j0[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char  <= 8'h00;
      held_valid <= 1'b0;
      in_comment <= 1'b0;
      block_open <= 1'b0;
    end else begin
      held_char  <= held_char_next;
      held_valid <= held_valid_next;
      in_comment <= in_comment_next;
      block_open <= block_open_next;
    end
  end

endmodule
`default_nettype wire

[hdl/cce_rbuf.sv]
`default_nettype none
module cce_rbuf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  cce_pkg::res_bundle_t      res,
  output logic                      room,
  output logic                      valid,
  input  wire logic                 ready,
  output cce_pkg::res_t             head
);

  cce_pkg::res_t              mem [cce_pkg::RBUF_DEPTH];
  logic [cce_pkg::RBUF_AW-1:0] wr_ptr;
  logic [cce_pkg::RBUF_AW-1:0] rd_ptr;
  logic [cce_pkg::RBUF_CW-1:0] count;
  logic                        pop;

  assign valid = count != '0;
  assign pop   = valid && ready;
  assign head  = mem[rd_ptr];
  assign room  = count <= cce_pkg::RBUF_CW'(cce_pkg::RBUF_DEPTH - cce_pkg::MAX_RES);

  always_ff @(posedge clk) begin
    for (int k = 0; k < cce_pkg::MAX_RES; k++) begin
      if (cce_pkg::RES_CW'(k) < res.n) begin
        mem[wr_ptr + cce_pkg::RBUF_AW'(k)] <= '{
          out_byte: res.bytes[k],
          run_last: cce_pkg::RES_CW'(k + 1) == res.n
        };
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cce_pkg::RBUF_AW'(res.n);
      if (pop) rd_ptr <= rd_ptr + cce_pkg::RBUF_AW'(1);
      count <= count + cce_pkg::RBUF_CW'(res.n) - cce_pkg::RBUF_CW'(pop);
    end
  end

endmodule
`default_nettype wire

[hdl/cce_checker.sv]
`default_nettype none
module cce_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

  // rest of a run is already queued
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("run broken before its last transfer");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // empty queue always has room
  a_empty_room: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with nothing queued");

endmodule

bind c_comment_line_extractor cce_checker u_cce_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_byte  (dout.out_byte),
  .out_last  (dout.run_last)
);
`default_nettype wire
